// ===== rtl/btzr_pkg.sv =====
// Shared types, widths and the edge function of the triangle rasterizer.
package btzr_pkg;

    localparam int COORD_W = 3;
    localparam int DEPTH_W = 8;
    localparam int COLOR_W = 24;
    localparam int EDGE_W  = 11;
    localparam int AREA_W  = 9;
    localparam int PROD_W  = 18;
    localparam int NUM_W   = 20;

    typedef logic signed [EDGE_W-1:0] t_edge;

    // One triangle after setup, as it waits in the queue.
    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [DEPTH_W-1:0] az;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [DEPTH_W-1:0] bz;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [DEPTH_W-1:0] cz;
        logic [COLOR_W-1:0] color;
        logic [AREA_W-1:0]  area;
        logic               neg;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
    } t_tri;

    // Twice the signed area of the triangle a, b, c.
    function automatic t_edge edge2(input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
                                    input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
                                    input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
        int v;
        v = (int'(by) - int'(ay)) * (int'(bx) + int'(ax))
          + (int'(cy) - int'(by)) * (int'(cx) + int'(bx))
          + (int'(ay) - int'(cy)) * (int'(ax) + int'(cx));
        return EDGE_W'(v);
    endfunction

endpackage

// ===== rtl/btzr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module btzr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/btzr_front.sv =====
// Front end: accepts a command, does triangle setup and queues it.
module btzr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_mode,
    input  logic [btzr_pkg::COORD_W-1:0]  i_ax,
    input  logic [btzr_pkg::COORD_W-1:0]  i_ay,
    input  logic [btzr_pkg::DEPTH_W-1:0]  i_az,
    input  logic [btzr_pkg::COORD_W-1:0]  i_bx,
    input  logic [btzr_pkg::COORD_W-1:0]  i_by,
    input  logic [btzr_pkg::DEPTH_W-1:0]  i_bz,
    input  logic [btzr_pkg::COORD_W-1:0]  i_cx,
    input  logic [btzr_pkg::COORD_W-1:0]  i_cy,
    input  logic [btzr_pkg::DEPTH_W-1:0]  i_cz,
    input  logic [btzr_pkg::COLOR_W-1:0]  i_color,
    input  logic                          i_pop,
    output logic                          o_full,
    output logic                          o_valid,
    output btzr_pkg::t_tri                o_tri
);

    btzr_pkg::t_tri r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    btzr_pkg::t_tri n_tri;
    btzr_pkg::t_edge s_raw;

    // Setup: doubled area, its sign and the bounding box.
    always_comb begin
        s_raw       = btzr_pkg::edge2(i_ax, i_ay, i_bx, i_by, i_cx, i_cy);
        n_tri.mode  = i_mode;
        n_tri.ax    = i_ax;
        n_tri.ay    = i_ay;
        n_tri.az    = i_az;
        n_tri.bx    = i_bx;
        n_tri.by    = i_by;
        n_tri.bz    = i_bz;
        n_tri.cx    = i_cx;
        n_tri.cy    = i_cy;
        n_tri.cz    = i_cz;
        n_tri.color = i_color;
        n_tri.neg   = s_raw[btzr_pkg::EDGE_W-1];
        n_tri.area  = n_tri.neg ? btzr_pkg::AREA_W'(-s_raw) : btzr_pkg::AREA_W'(s_raw);
        n_tri.x0    = (i_ax < i_bx) ? i_ax : i_bx;
        n_tri.x0    = (n_tri.x0 < i_cx) ? n_tri.x0 : i_cx;
        n_tri.x1    = (i_ax > i_bx) ? i_ax : i_bx;
        n_tri.x1    = (n_tri.x1 > i_cx) ? n_tri.x1 : i_cx;
        n_tri.y0    = (i_ay < i_by) ? i_ay : i_by;
        n_tri.y0    = (n_tri.y0 < i_cy) ? n_tri.y0 : i_cy;
        n_tri.y1    = (i_ay > i_by) ? i_ay : i_by;
        n_tri.y1    = (n_tri.y1 > i_cy) ? n_tri.y1 : i_cy;
    end

    // Two-entry queue toward the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_q[r_wp] <= n_tri;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tri   = r_q[r_rp];

endmodule

// ===== rtl/btzr_div.sv =====
// Restoring divider: one quotient bit per cycle, quotient known to fit in eight bits.
module btzr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [btzr_pkg::NUM_W-1:0]   i_num,
    input  logic [btzr_pkg::AREA_W-1:0]  i_den,
    output logic                         o_done,
    output logic [btzr_pkg::DEPTH_W-1:0] o_quot
);

    logic                         r_busy;
    logic                         r_done;
    logic [2:0]                   r_cnt;
    logic [btzr_pkg::NUM_W-1:0]   r_rem;
    logic [btzr_pkg::AREA_W-1:0]  r_den;
    logic [btzr_pkg::DEPTH_W-1:0] r_quot;
    logic [btzr_pkg::NUM_W-1:0]   shifted;

    assign shifted = btzr_pkg::NUM_W'(r_den) << r_cnt;

    // One compare and subtract per cycle, highest quotient bit first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd7;
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                if (r_rem >= shifted) begin
                    r_rem         <= r_rem - shifted;
                    r_quot[r_cnt] <= 1'b1;
                end
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/btzr_back.sv =====
// Back end: walks the bounding box, tests edges and depth, updates the depth store.
module btzr_back #(
    parameter int SCREEN_WIDTH  = 8,
    parameter int SCREEN_HEIGHT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  btzr_pkg::t_tri               i_tri,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic [btzr_pkg::COORD_W-1:0] o_col,
    output logic [btzr_pkg::COORD_W-1:0] o_row,
    output logic [btzr_pkg::COLOR_W-1:0] o_color,
    output logic [btzr_pkg::DEPTH_W-1:0] o_depth,
    output logic                         o_valid,
    output logic                         o_last
);

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EDGE  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_FLUSH = 7'b1000000
    } t_state;

    t_state                       r_state;
    btzr_pkg::t_tri               r_tri;
    logic [btzr_pkg::COORD_W-1:0] r_px;
    logic [btzr_pkg::COORD_W-1:0] r_py;
    logic [CELLS-1:0]             r_vld;
    logic [AW-1:0]                r_idx;
    btzr_pkg::t_edge              r_e1;
    btzr_pkg::t_edge              r_e2;
    btzr_pkg::t_edge              r_e3;
    logic [btzr_pkg::PROD_W-1:0]  r_p1;
    logic [btzr_pkg::PROD_W-1:0]  r_p2;
    logic [btzr_pkg::PROD_W-1:0]  r_p3;
    logic [btzr_pkg::NUM_W-1:0]   r_ref;
    logic                         r_have;
    logic [btzr_pkg::COORD_W-1:0] r_pcol;
    logic [btzr_pkg::COORD_W-1:0] r_prow;
    logic [btzr_pkg::DEPTH_W-1:0] r_pdepth;
    logic                         r_strobe;
    logic [btzr_pkg::COORD_W-1:0] r_col;
    logic [btzr_pkg::COORD_W-1:0] r_row;
    logic [btzr_pkg::COLOR_W-1:0] r_color;
    logic [btzr_pkg::DEPTH_W-1:0] r_depth;
    logic                         r_valid;
    logic                         r_last;

    btzr_pkg::t_edge              e1;
    btzr_pkg::t_edge              e2;
    btzr_pkg::t_edge              e3;
    logic                         on_screen;
    logic [AW-1:0]                idx;
    logic [btzr_pkg::NUM_W-1:0]   num;
    logic [btzr_pkg::DEPTH_W-1:0] ram_q;
    logic [btzr_pkg::DEPTH_W-1:0] stored;
    logic                         div_start;
    logic                         div_done;
    logic [btzr_pkg::DEPTH_W-1:0] div_quot;
    logic                         ram_we;

    // Edge values of the current pixel, sign-normalized by the area.
    always_comb begin
        e1 = btzr_pkg::edge2(r_px, r_py, r_tri.bx, r_tri.by, r_tri.cx, r_tri.cy);
        e2 = btzr_pkg::edge2(r_px, r_py, r_tri.cx, r_tri.cy, r_tri.ax, r_tri.ay);
        e3 = btzr_pkg::edge2(r_px, r_py, r_tri.ax, r_tri.ay, r_tri.bx, r_tri.by);
        if (r_tri.neg) begin
            e1 = -e1;
            e2 = -e2;
            e3 = -e3;
        end
        on_screen = (int'(r_px) < SCREEN_WIDTH) && (int'(r_py) < SCREEN_HEIGHT);
        idx       = AW'(int'(r_py) * SCREEN_WIDTH + int'(r_px));
        num       = btzr_pkg::NUM_W'(r_p1) + btzr_pkg::NUM_W'(r_p2)
                  + btzr_pkg::NUM_W'(r_p3);
        stored    = r_vld[r_idx] ? ram_q : '0;
    end

    assign div_start = (r_state == S_CMP) && (r_ref < num);
    assign ram_we    = (r_state == S_DIV) && div_done;
    assign o_pop     = (r_state == S_IDLE) && i_valid;

    btzr_ram #(
        .WIDTH (btzr_pkg::DEPTH_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (div_quot),
        .i_re    (r_state == S_EDGE),
        .i_raddr (idx),
        .o_rdata (ram_q)
    );

    btzr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (r_tri.area),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Pixel walk sequencer; a drawn pixel is held back one beat to mark the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= '0;
            r_have   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tri  <= i_tri;
                        r_px   <= i_tri.x0;
                        r_py   <= i_tri.y0;
                        r_have <= 1'b0;
                        if (!i_tri.mode || i_tri.area == '0) begin
                            if (!i_tri.mode) begin
                                r_vld <= '0;
                            end
                            r_strobe <= 1'b1;
                            r_col    <= '0;
                            r_row    <= '0;
                            r_color  <= '0;
                            r_depth  <= '0;
                            r_valid  <= 1'b0;
                            r_last   <= 1'b1;
                        end else begin
                            r_state <= S_EDGE;
                        end
                    end
                end
                S_EDGE: begin
                    r_e1  <= e1;
                    r_e2  <= e2;
                    r_e3  <= e3;
                    r_idx <= idx;
                    if (!on_screen || e1 < 0 || e2 < 0 || e3 < 0) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p1    <= btzr_pkg::PROD_W'(r_e1[btzr_pkg::EDGE_W-2:0])
                             * btzr_pkg::PROD_W'(r_tri.az);
                    r_p2    <= btzr_pkg::PROD_W'(r_e2[btzr_pkg::EDGE_W-2:0])
                             * btzr_pkg::PROD_W'(r_tri.bz);
                    r_p3    <= btzr_pkg::PROD_W'(r_e3[btzr_pkg::EDGE_W-2:0])
                             * btzr_pkg::PROD_W'(r_tri.cz);
                    r_ref   <= btzr_pkg::NUM_W'(stored) * btzr_pkg::NUM_W'(r_tri.area);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= div_start ? S_DIV : S_NEXT;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_vld[r_idx] <= 1'b1;
                        if (r_have) begin
                            r_strobe <= 1'b1;
                            r_col    <= r_pcol;
                            r_row    <= r_prow;
                            r_color  <= r_tri.color;
                            r_depth  <= r_pdepth;
                            r_valid  <= 1'b1;
                            r_last   <= 1'b0;
                        end
                        r_have   <= 1'b1;
                        r_pcol   <= r_px;
                        r_prow   <= r_py;
                        r_pdepth <= div_quot;
                        r_state  <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_px == r_tri.x1 && r_py == r_tri.y1) begin
                        r_state <= S_FLUSH;
                    end else begin
                        if (r_py == r_tri.y1) begin
                            r_py <= r_tri.y0;
                            r_px <= r_px + btzr_pkg::COORD_W'(1);
                        end else begin
                            r_py <= r_py + btzr_pkg::COORD_W'(1);
                        end
                        r_state <= S_EDGE;
                    end
                end
                S_FLUSH: begin
                    r_strobe <= 1'b1;
                    r_last   <= 1'b1;
                    r_valid  <= r_have;
                    r_col    <= r_have ? r_pcol : '0;
                    r_row    <= r_have ? r_prow : '0;
                    r_color  <= r_have ? r_tri.color : '0;
                    r_depth  <= r_have ? r_pdepth : '0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_col    = r_col;
    assign o_row    = r_row;
    assign o_color  = r_color;
    assign o_depth  = r_depth;
    assign o_valid  = r_valid;
    assign o_last   = r_last;

endmodule

// ===== rtl/barycentric_triangle_zbuffer_raster.sv =====
// Top level of the triangle rasterizer with depth store.
// A clear or zero-area triangle gives its marker straight from the idle state of the back end.
// Other triangles walk the bounding box one pixel at a time; each drawn pixel waits on the
// 8-step divider, and the next command is popped only once the last one is done.
// A two-entry command queue holds busy low until it is full; results cannot stall.
// Synchronous reset empties the queue and marks the whole depth store as zero.
module barycentric_triangle_zbuffer_raster #(
    parameter int SCREEN_WIDTH  = 8,
    parameter int SCREEN_HEIGHT = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_mode,
    input  logic [btzr_pkg::COORD_W-1:0] i_vert_a_x,
    input  logic [btzr_pkg::COORD_W-1:0] i_vert_a_y,
    input  logic [btzr_pkg::DEPTH_W-1:0] i_vert_a_depth,
    input  logic [btzr_pkg::COORD_W-1:0] i_vert_b_x,
    input  logic [btzr_pkg::COORD_W-1:0] i_vert_b_y,
    input  logic [btzr_pkg::DEPTH_W-1:0] i_vert_b_depth,
    input  logic [btzr_pkg::COORD_W-1:0] i_vert_c_x,
    input  logic [btzr_pkg::COORD_W-1:0] i_vert_c_y,
    input  logic [btzr_pkg::DEPTH_W-1:0] i_vert_c_depth,
    input  logic [btzr_pkg::COLOR_W-1:0] i_fill_color,
    output logic                         o_strobe,
    output logic [btzr_pkg::COORD_W-1:0] o_pixel_col,
    output logic [btzr_pkg::COORD_W-1:0] o_pixel_row,
    output logic [btzr_pkg::COLOR_W-1:0] o_pixel_color,
    output logic [btzr_pkg::DEPTH_W-1:0] o_pixel_depth,
    output logic                         o_pixel_valid,
    output logic                         o_last_of_run
);

    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    btzr_pkg::t_tri q_tri;

    assign busy = q_full;

    btzr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !q_full),
        .i_mode  (i_mode),
        .i_ax    (i_vert_a_x),
        .i_ay    (i_vert_a_y),
        .i_az    (i_vert_a_depth),
        .i_bx    (i_vert_b_x),
        .i_by    (i_vert_b_y),
        .i_bz    (i_vert_b_depth),
        .i_cx    (i_vert_c_x),
        .i_cy    (i_vert_c_y),
        .i_cz    (i_vert_c_depth),
        .i_color (i_fill_color),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tri   (q_tri)
    );

    btzr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_tri    (q_tri),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_col    (o_pixel_col),
        .o_row    (o_pixel_row),
        .o_color  (o_pixel_color),
        .o_depth  (o_pixel_depth),
        .o_valid  (o_pixel_valid),
        .o_last   (o_last_of_run)
    );

    // An empty marker always closes its command.
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_pixel_valid |-> o_last_of_run)
        else $error("empty marker without last flag");

    // Drawn pixels lie on the screen.
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_pixel_valid |->
            (int'(o_pixel_col) < SCREEN_WIDTH) && (int'(o_pixel_row) < SCREEN_HEIGHT))
        else $error("pixel outside the screen");

    // No result beat follows directly out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result beat after reset");

endmodule
